/* src/acf_pkg.sv */
// Shared constants, types and functions for the complementary attitude filter.
package acf_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int N_ITER = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS
                                                               : ATAN_ENTRIES;
    localparam int CNT_W     = 5;
    localparam int MUL_W     = 24;
    localparam int MUL_STEPS = MUL_W;
    localparam int ACC_W     = 64;
    localparam int CX_W      = 46;
    localparam int CZ_W      = 34;
    localparam int SQ_W      = 48;
    localparam int AXIS_W    = 17;

    localparam logic [MUL_W-1:0]       RATE_K      = 24'd4685083;
    localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // register indexes
    localparam logic [2:0] REG_ACC_OFF_X  = 3'd0;
    localparam logic [2:0] REG_ACC_OFF_Y  = 3'd1;
    localparam logic [2:0] REG_ACC_OFF_Z  = 3'd2;
    localparam logic [2:0] REG_GYRO_OFF_X = 3'd3;
    localparam logic [2:0] REG_GYRO_OFF_Z = 3'd4;
    localparam logic [2:0] REG_BLEND_GAIN = 3'd5;
    localparam logic [2:0] REG_YAW_FORGET = 3'd6;
    localparam logic [2:0] REG_SAMPLE_PER = 3'd7;

    typedef struct packed {
        logic load;
        logic clear;
        logic step;
    } t_mac_ctl;

    function automatic logic [31:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

/* src/imu_complementary_attitude_filter.sv */
// Top level of the complementary roll/pitch/yaw attitude filter.
//
//  channel | dir | handshake                      | word
//  s_axis  | in  | s_axis_tvalid / s_axis_tready  | 6 x 16b IMU sample
//  m_axis  | out | m_axis_tvalid / m_axis_tready  | 3 x 32b Q15.16 angles
//  apb     | in  | psel & penable & pwrite        | 8 registers at 4*i
//
// One word in flight: each word passes through four bit-serial multiply passes
// (a load, then one step per multiplier bit) in each of three lanes (g*h, *K,
// two blend terms), then a wait, a write-back and the accept state; square
// root and both CORDIC runs overlap the first two passes.
// Reset (synchronous, active low) zeroes the three estimates; registers
// return to their defaults. A held result on m_axis only stalls write-back;
// s_axis is ready again once the result is in the output register.
module imu_complementary_attitude_filter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16b each, from bit 0)
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // roll_angle, pitch_angle, yaw_angle (32b each, from bit 0)
    output logic [95:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int NL = 3;

    typedef enum logic [2:0] {S_IDLE, S_GH, S_GK, S_WAIT, S_B1, S_B2, S_WB} t_state;

    t_state r_state;
    logic [acf_pkg::CNT_W-1:0] r_cnt;

    // configuration
    logic signed [12:0] r_aox, r_aoy, r_aoz, r_gox, r_goz;
    logic [15:0]        r_gamma, r_forget, r_h;

    // item payload
    logic signed [acf_pkg::AXIS_W-1:0] r_axc, r_ayc, r_azc;
    logic signed [acf_pkg::AXIS_W-1:0] r_g [NL];
    logic signed [31:0] r_est [NL];
    logic [95:0]        r_out;
    logic               r_out_valid;
    logic               r_ang_start;

    logic w_in_acc, w_wb_go, w_ang_done;
    logic signed [31:0] w_roll, w_pitch;
    logic signed [acf_pkg::AXIS_W-1:0] w_axc, w_ayc, w_azc, w_gxc, w_gzc;
    acf_pkg::t_mac_ctl w_ctl;
    logic signed [acf_pkg::ACC_W-1:0] w_mcand [NL];
    logic [acf_pkg::MUL_W-1:0]        w_mult  [NL];
    logic signed [acf_pkg::ACC_W-1:0] w_acc   [NL];
    logic signed [31:0]               w_new   [NL];
    logic signed [31:0]               w_ang   [NL];

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_wb_go       = (r_state == S_WB) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // offsets applied at accept
    assign w_axc = acf_pkg::AXIS_W'($signed(s_axis_tdata[15:0])) + acf_pkg::AXIS_W'(r_aox);
    assign w_ayc = acf_pkg::AXIS_W'($signed(s_axis_tdata[31:16])) + acf_pkg::AXIS_W'(r_aoy);
    assign w_azc = acf_pkg::AXIS_W'($signed(s_axis_tdata[47:32])) + acf_pkg::AXIS_W'(r_aoz);
    assign w_gxc = acf_pkg::AXIS_W'($signed(s_axis_tdata[63:48])) + acf_pkg::AXIS_W'(r_gox);
    assign w_gzc = acf_pkg::AXIS_W'($signed(s_axis_tdata[95:80])) + acf_pkg::AXIS_W'(r_goz);

    // register read-back
    always_comb begin
        unique case (paddr[4:2])
            acf_pkg::REG_ACC_OFF_X:  prdata = {19'd0, r_aox};
            acf_pkg::REG_ACC_OFF_Y:  prdata = {19'd0, r_aoy};
            acf_pkg::REG_ACC_OFF_Z:  prdata = {19'd0, r_aoz};
            acf_pkg::REG_GYRO_OFF_X: prdata = {19'd0, r_gox};
            acf_pkg::REG_GYRO_OFF_Z: prdata = {19'd0, r_goz};
            acf_pkg::REG_BLEND_GAIN: prdata = {16'd0, r_gamma};
            acf_pkg::REG_YAW_FORGET: prdata = {16'd0, r_forget};
            acf_pkg::REG_SAMPLE_PER: prdata = {16'd0, r_h};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aox    <= 13'sd287;
            r_aoy    <= 13'sd369;
            r_aoz    <= -13'sd737;
            r_gox    <= 13'sd19;
            r_goz    <= -13'sd10;
            r_gamma  <= 16'd52429;
            r_forget <= 16'd64881;
            r_h      <= 16'd1638;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                acf_pkg::REG_ACC_OFF_X:  r_aox    <= pwdata[12:0];
                acf_pkg::REG_ACC_OFF_Y:  r_aoy    <= pwdata[12:0];
                acf_pkg::REG_ACC_OFF_Z:  r_aoz    <= pwdata[12:0];
                acf_pkg::REG_GYRO_OFF_X: r_gox    <= pwdata[12:0];
                acf_pkg::REG_GYRO_OFF_Z: r_goz    <= pwdata[12:0];
                acf_pkg::REG_BLEND_GAIN: r_gamma  <= pwdata[15:0];
                acf_pkg::REG_YAW_FORGET: r_forget <= pwdata[15:0];
                acf_pkg::REG_SAMPLE_PER: r_h      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // lane control: load at count zero, then one serial step per cycle
    always_comb begin
        w_ctl.load  = (r_cnt == '0) && (r_state == S_GH || r_state == S_GK ||
                                         r_state == S_B1 || r_state == S_B2);
        w_ctl.clear = w_ctl.load && (r_state != S_B2);
        w_ctl.step  = (r_cnt != '0);
    end

    assign w_ang[0] = w_roll;
    assign w_ang[1] = w_pitch;
    assign w_ang[2] = 32'sd0;

    // lane 0 roll, lane 1 pitch, lane 2 yaw
    always_comb begin
        for (int k = 0; k < NL; k++) begin
            w_mcand[k] = '0;
            w_mult[k]  = '0;
            unique case (r_state)
                S_GH: begin
                    w_mcand[k] = acf_pkg::ACC_W'(r_g[k]);
                    w_mult[k]  = acf_pkg::MUL_W'(r_h);
                end
                S_GK: begin
                    w_mcand[k] = w_acc[k];
                    w_mult[k]  = acf_pkg::RATE_K;
                end
                S_B1: begin
                    // estimate plus rounded gyro increment
                    w_mcand[k] = acf_pkg::ACC_W'(r_est[k]) +
                                 ((w_acc[k] + (64'sd1 <<< 31)) >>> 32);
                    w_mult[k]  = (k == NL - 1) ? acf_pkg::MUL_W'(r_forget)
                                               : acf_pkg::MUL_W'(r_gamma);
                end
                S_B2: begin
                    w_mcand[k] = acf_pkg::ACC_W'(w_ang[k]);
                    w_mult[k]  = (k == NL - 1) ? '0
                                 : acf_pkg::MUL_W'(17'h10000 - {1'b0, r_gamma});
                end
                default: ;
            endcase
            w_new[k] = acf_pkg::sat32((w_acc[k] + (64'sd1 <<< 15)) >>> 16);
        end
    end

    for (genvar gk = 0; gk < NL; gk++) begin : g_lane
        acf_mac u_mac (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_mcand (w_mcand[gk]),
            .i_mult  (w_mult[gk]),
            .o_acc   (w_acc[gk])
        );
    end

    acf_angle u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ang_start),
        .i_axc   (r_axc),
        .i_ayc   (r_ayc),
        .i_azc   (r_azc),
        .o_done  (w_ang_done),
        .o_roll  (w_roll),
        .o_pitch (w_pitch)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_ang_start <= 1'b0;
            for (int k = 0; k < NL; k++) begin
                r_est[k] <= '0;
            end
        end else begin
            r_ang_start <= w_in_acc;
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        // remap: gx=-gy, gy=gx, gz=-gz
                        r_axc   <= w_axc;
                        r_ayc   <= w_ayc;
                        r_azc   <= w_azc;
                        r_g[0]  <= -acf_pkg::AXIS_W'($signed(s_axis_tdata[79:64]));
                        r_g[1]  <= w_gxc;
                        r_g[2]  <= -w_gzc;
                        r_cnt   <= '0;
                        r_state <= S_GH;
                    end
                end
                S_GH, S_GK, S_B1, S_B2: begin
                    if (r_cnt == acf_pkg::CNT_W'(acf_pkg::MUL_STEPS)) begin
                        r_cnt <= '0;
                        unique case (r_state)
                            S_GH:    r_state <= S_GK;
                            S_GK:    r_state <= S_WAIT;
                            S_B1:    r_state <= S_B2;
                            default: r_state <= S_WB;
                        endcase
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WAIT: begin
                    if (w_ang_done) begin
                        r_state <= S_B1;
                    end
                end
                S_WB: begin
                    if (w_wb_go) begin
                        for (int k = 0; k < NL; k++) begin
                            r_est[k] <= w_new[k];
                        end
                        r_out       <= {w_new[2], w_new[1], w_new[0]};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= acf_pkg::CNT_W'(acf_pkg::MUL_STEPS))
        else $error("serial step count overran");

    a_out_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_WB)
        else $error("result raised outside write-back");

    a_wb_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wb_go |=> (m_axis_tdata == {r_est[2], r_est[1], r_est[0]}))
        else $error("output word differs from stored estimates");
`endif

endmodule

/* src/acf_mac.sv */
// Bit-serial signed-by-unsigned multiply-accumulate lane.
module acf_mac (
    input  logic                                i_clk,
    input  acf_pkg::t_mac_ctl                   i_ctl,
    input  logic signed [acf_pkg::ACC_W-1:0]    i_mcand,
    input  logic [acf_pkg::MUL_W-1:0]           i_mult,
    output logic signed [acf_pkg::ACC_W-1:0]    o_acc
);

    logic signed [acf_pkg::ACC_W-1:0] r_acc;
    logic signed [acf_pkg::ACC_W-1:0] r_mcand;
    logic [acf_pkg::MUL_W-1:0]        r_mult;

    // one multiplier bit per cycle, LSB first
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand <= i_mcand;
            r_mult  <= i_mult;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end
        end else if (i_ctl.step) begin
            if (r_mult[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand <= r_mcand <<< 1;
            r_mult  <= r_mult >> 1;
        end
    end

    assign o_acc = r_acc;

endmodule

/* src/acf_angle.sv */
// Accelerometer angles: iterative square root and shared CORDIC atan2 unit.
module acf_angle (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [acf_pkg::AXIS_W-1:0]    i_axc,
    input  logic signed [acf_pkg::AXIS_W-1:0]    i_ayc,
    input  logic signed [acf_pkg::AXIS_W-1:0]    i_azc,
    output logic                                 o_done,
    output logic signed [31:0]                   o_roll,
    output logic signed [31:0]                   o_pitch
);

    typedef enum logic [2:0] {A_IDLE, A_SQ, A_ROLL, A_PLOAD, A_PITCH, A_DONE} t_state;

    typedef struct packed {
        logic                                zero;
        logic signed [acf_pkg::CX_W-1:0]     x;
        logic signed [acf_pkg::CX_W-1:0]     y;
        logic signed [acf_pkg::CZ_W-1:0]     z;
    } t_cord;

    t_state r_state;
    logic [acf_pkg::CNT_W-1:0] r_scnt;
    logic [acf_pkg::CNT_W-1:0] r_ccnt;
    logic signed [2*acf_pkg::AXIS_W-1:0] r_sqa;
    logic signed [2*acf_pkg::AXIS_W-1:0] r_sqb;
    logic [acf_pkg::SQ_W-1:0] r_rem;
    logic [acf_pkg::SQ_W-1:0] r_res;
    logic [acf_pkg::SQ_W-1:0] r_bit;
    logic                             r_zero;
    logic signed [acf_pkg::CX_W-1:0]  r_cx;
    logic signed [acf_pkg::CX_W-1:0]  r_cy;
    logic signed [acf_pkg::CZ_W-1:0]  r_cz;
    logic signed [31:0]               r_roll;

    logic [acf_pkg::SQ_W-1:0]         w_trial;
    logic                             w_ge;
    logic signed [acf_pkg::CX_W-1:0]  w_xs;
    logic signed [acf_pkg::CX_W-1:0]  w_ys;
    logic signed [acf_pkg::CZ_W-1:0]  w_at;
    logic signed [31:0]               w_angle;
    t_cord                            w_roll_init;
    t_cord                            w_pitch_init;

    function automatic t_cord cord_init(input logic signed [acf_pkg::CX_W-1:0] x,
                                        input logic signed [acf_pkg::CX_W-1:0] y);
        t_cord c;
        c.zero = (x == '0) && (y == '0);
        c.x    = x;
        c.y    = y;
        c.z    = '0;
        // quarter-turn pre-rotation for the left half plane
        if (x < 0) begin
            if (y >= 0) begin
                c.x = y;
                c.y = -x;
                c.z = acf_pkg::HALF_PI_Q30;
            end else begin
                c.x = -y;
                c.y = x;
                c.z = -acf_pkg::HALF_PI_Q30;
            end
        end
        return c;
    endfunction

    always_comb begin
        w_trial = r_res + r_bit;
        w_ge    = (r_rem >= w_trial);
        w_xs    = r_cx >>> r_ccnt;
        w_ys    = r_cy >>> r_ccnt;
        w_at    = $signed({2'b00, acf_pkg::atan_q30(r_ccnt)});
        w_angle = r_zero ? 32'sd0
                         : 32'((r_cz + (34'sd1 <<< 13)) >>> 14);
        w_roll_init  = cord_init((-acf_pkg::CX_W'(i_azc)) <<< 16,
                                 acf_pkg::CX_W'(i_axc) <<< 16);
        w_pitch_init = cord_init($signed({{(acf_pkg::CX_W-24){1'b0}}, r_res[23:0]}) <<< 16,
                                 acf_pkg::CX_W'(i_ayc) <<< 24);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_scnt  <= '0;
            r_ccnt  <= '0;
        end else begin
            unique case (r_state)
                A_IDLE, A_DONE: begin
                    if (i_start) begin
                        r_sqa   <= i_axc * i_axc;
                        r_sqb   <= i_azc * i_azc;
                        r_state <= A_SQ;
                    end
                end
                A_SQ: begin
                    r_rem  <= acf_pkg::SQ_W'($unsigned(r_sqa) + $unsigned(r_sqb)) << 16;
                    r_res  <= '0;
                    r_bit  <= acf_pkg::SQ_W'(1) << 46;
                    r_scnt <= '0;
                    r_ccnt <= '0;
                    r_zero <= w_roll_init.zero;
                    r_cx   <= w_roll_init.x;
                    r_cy   <= w_roll_init.y;
                    r_cz   <= w_roll_init.z;
                    r_state <= A_ROLL;
                end
                A_ROLL: begin
                    // square root: one result bit per cycle
                    if (w_ge) begin
                        r_rem <= r_rem - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_scnt <= r_scnt + 1'b1;
                    // roll CORDIC runs alongside
                    if (r_ccnt < acf_pkg::CNT_W'(acf_pkg::N_ITER)) begin
                        if (r_cy >= 0) begin
                            r_cx <= r_cx + w_ys;
                            r_cy <= r_cy - w_xs;
                            r_cz <= r_cz + w_at;
                        end else begin
                            r_cx <= r_cx - w_ys;
                            r_cy <= r_cy + w_xs;
                            r_cz <= r_cz - w_at;
                        end
                        r_ccnt <= r_ccnt + 1'b1;
                    end
                    if (r_scnt == 5'd23) begin
                        r_state <= A_PLOAD;
                    end
                end
                A_PLOAD: begin
                    r_roll  <= w_angle;
                    r_ccnt  <= '0;
                    r_zero  <= w_pitch_init.zero;
                    r_cx    <= w_pitch_init.x;
                    r_cy    <= w_pitch_init.y;
                    r_cz    <= w_pitch_init.z;
                    r_state <= A_PITCH;
                end
                A_PITCH: begin
                    if (r_cy >= 0) begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + w_at;
                    end else begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - w_at;
                    end
                    r_ccnt <= r_ccnt + 1'b1;
                    if (r_ccnt == acf_pkg::CNT_W'(acf_pkg::N_ITER - 1)) begin
                        r_state <= A_DONE;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_done  = (r_state == A_DONE);
    assign o_roll  = r_roll;
    assign o_pitch = w_angle;

endmodule

/* sim/acf_checker.sv */
`timescale 1ns / 1ps
// Checker for the attitude filter: predicts each result word and compares it.
module acf_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [95:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic signed [31:0] roll;
        logic signed [31:0] pitch;
        logic signed [31:0] yaw;
    } t_angles;

    localparam longint ARC_TAB [24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    logic [15:0] cfg [8];
    longint      roll_q, pitch_q, yaw_q;
    t_angles     angle_queue [$];

    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w >>= 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v -= res + bit_w;
                res = (res >> 1) + bit_w;
            end else begin
                res >>= 1;
            end
            bit_w >>= 2;
        end
        return longint'(res);
    endfunction

    // vectoring CORDIC, result in Q15.16 radians
    function automatic longint arc_tan2(longint y, longint x);
        longint z, t, xs, ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = acf_pkg::HALF_PI_Q30;
            end else begin
                x = -y; y = t; z = -acf_pkg::HALF_PI_Q30;
            end
        end
        for (int i = 0; i < acf_pkg::N_ITER; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += ARC_TAB[i];
            end else begin
                x -= ys; y += xs; z -= ARC_TAB[i];
            end
        end
        return round_shift(z, 14);
    endfunction

    function automatic longint rate_step(longint g, longint h);
        return round_shift(g * h * longint'(acf_pkg::RATE_K), 32);
    endfunction

    function automatic longint off13(logic [15:0] r);
        return longint'($signed(r[12:0]));
    endfunction

    function automatic longint raw16(logic [95:0] w, int k);
        return longint'($signed(w[16*k +: 16]));
    endfunction

    // advance the attitude estimate by one sample
    function automatic t_angles update_attitude(logic [95:0] w);
        longint ax, ay, az, gx, gy, gz, gamma, forget, h;
        longint acc_roll, acc_pitch, mag, rsum, psum, ysum;
        longint unsigned sq;
        t_angles a;
        ax = raw16(w, 1) + off13(cfg[acf_pkg::REG_ACC_OFF_Y]);
        ay = -(raw16(w, 0) + off13(cfg[acf_pkg::REG_ACC_OFF_X]));
        az = raw16(w, 2) + off13(cfg[acf_pkg::REG_ACC_OFF_Z]);
        gx = -raw16(w, 4);
        gy = raw16(w, 3) + off13(cfg[acf_pkg::REG_GYRO_OFF_X]);
        gz = -(raw16(w, 5) + off13(cfg[acf_pkg::REG_GYRO_OFF_Z]));
        gamma  = longint'(cfg[acf_pkg::REG_BLEND_GAIN]);
        forget = longint'(cfg[acf_pkg::REG_YAW_FORGET]);
        h      = longint'(cfg[acf_pkg::REG_SAMPLE_PER]);
        acc_roll = arc_tan2(-ay, -az);
        sq  = longint'(ay * ay) + longint'(az * az);
        mag = int_sqrt(sq << 16);
        acc_pitch = arc_tan2(ax * 256, mag);
        rsum = roll_q + rate_step(gx, h);
        psum = pitch_q + rate_step(gy, h);
        ysum = yaw_q + rate_step(gz, h);
        roll_q  = clamp32(round_shift(rsum * gamma + acc_roll * (65536 - gamma), 16));
        pitch_q = clamp32(round_shift(psum * gamma + acc_pitch * (65536 - gamma), 16));
        yaw_q   = clamp32(round_shift(ysum * forget, 16));
        a.roll  = roll_q[31:0];
        a.pitch = pitch_q[31:0];
        a.yaw   = yaw_q[31:0];
        return a;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(exp_v),
                   $signed(act_v));
            o_fail_count++;
        end
    endtask

    assign o_pending = angle_queue.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_angles e;
        if (!i_rst_n) begin
            cfg[acf_pkg::REG_ACC_OFF_X]  <= 16'(287);
            cfg[acf_pkg::REG_ACC_OFF_Y]  <= 16'(369);
            cfg[acf_pkg::REG_ACC_OFF_Z]  <= 16'(8192 - 737);
            cfg[acf_pkg::REG_GYRO_OFF_X] <= 16'(19);
            cfg[acf_pkg::REG_GYRO_OFF_Z] <= 16'(8192 - 10);
            cfg[acf_pkg::REG_BLEND_GAIN] <= 16'(52429);
            cfg[acf_pkg::REG_YAW_FORGET] <= 16'(64881);
            cfg[acf_pkg::REG_SAMPLE_PER] <= 16'(1638);
            roll_q  = 0;
            pitch_q = 0;
            yaw_q   = 0;
            angle_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[4:2] inside {acf_pkg::REG_BLEND_GAIN, acf_pkg::REG_YAW_FORGET,
                                       acf_pkg::REG_SAMPLE_PER})
                    cfg[paddr[4:2]] <= pwdata[15:0];
                else
                    cfg[paddr[4:2]] <= {3'b000, pwdata[12:0]};
            end
            if (s_axis_tvalid && s_axis_tready)
                angle_queue.push_back(update_attitude(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                if (angle_queue.size() == 0) begin
                    $error("result word with nothing expected: %h", m_axis_tdata);
                    o_fail_count++;
                end else begin
                    e = angle_queue.pop_front();
                    check_field("roll_angle", e.roll, m_axis_tdata[31:0]);
                    check_field("pitch_angle", e.pitch, m_axis_tdata[63:32]);
                    check_field("yaw_angle", e.yaw, m_axis_tdata[95:64]);
                end
            end
        end
    end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the complementary attitude filter.
module testbench;

    localparam int STALL_LIMIT = 6000;  // cycles without any handshake
    localparam int LONG_HOLD   = 700;   // receiver hold-off, well over one word time

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count, pending;
    int words_sent = 0;
    int settings_run = 1;
    bit quiet = 1'b0;        // no idling on either side
    bit long_hold_req = 1'b0;
    bit push_gyro = 1'b0;    // drive gyros hard to reach saturation
    int stall_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    imu_complementary_attitude_filter dut (.*);

    acf_checker u_checker (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: any accepted word or register write counts as progress
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("** imu_complementary_attitude_filter: FAILED **");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random backpressure bursts, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
            end else if (quiet || $urandom_range(3) != 0) begin
                m_axis_tready <= 1'b1;
                n = quiet ? 0 : $urandom_range(30, 1);
                repeat (n) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(15, 1);
                repeat (n) @(negedge i_clk);
            end
        end
    end

    task automatic send_sample(logic [95:0] w);
        int gap;
        gap = (quiet || $urandom_range(2) != 0) ? 0 : $urandom_range(15, 1);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // drain the filter, then load a full register setting
    task automatic load_setting(int aox, int aoy, int aoz, int gox, int goz,
                                int gain, int forget, int period);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge i_clk);
        write_reg(acf_pkg::REG_ACC_OFF_X, aox);
        write_reg(acf_pkg::REG_ACC_OFF_Y, aoy);
        write_reg(acf_pkg::REG_ACC_OFF_Z, aoz);
        write_reg(acf_pkg::REG_GYRO_OFF_X, gox);
        write_reg(acf_pkg::REG_GYRO_OFF_Z, goz);
        write_reg(acf_pkg::REG_BLEND_GAIN, gain);
        write_reg(acf_pkg::REG_YAW_FORGET, forget);
        write_reg(acf_pkg::REG_SAMPLE_PER, period);
        settings_run++;
    endtask

    function automatic logic [15:0] near(int center, int spread);
        return 16'(center + $urandom_range(2 * spread) - spread);
    endfunction

    function automatic logic [95:0] pack6(logic [15:0] ax, logic [15:0] ay,
                                          logic [15:0] az, logic [15:0] gx,
                                          logic [15:0] gy, logic [15:0] gz);
        return {gz, gy, gx, az, ay, ax};
    endfunction

    // mostly plausible gravity plus rates, some raw noise and some extremes
    function automatic logic [95:0] random_sample();
        logic [15:0] f [6];
        int kind;
        kind = $urandom_range(9);
        for (int k = 0; k < 6; k++) begin
            if (kind < 6)
                f[k] = (k < 3) ? near((k == 2) ? -4096 : 0, 4096) : near(0, 2000);
            else if (kind < 9)
                f[k] = 16'($urandom);
            else
                f[k] = ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
        end
        if (push_gyro) begin
            f[3] = near(-32000, 700);
            f[4] = near(32000, 700);
            f[5] = near(32000, 700);
        end
        return pack6(f[0], f[1], f[2], f[3], f[4], f[5]);
    endfunction

    task automatic random_run(int n);
        for (int i = 0; i < n; i++) send_sample(random_sample());
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed, reset settings
        // accel vector cancelled by the offsets -> zero-vector atan2
        send_sample(pack6(16'(-287), 16'(-369), 16'(737), 16'd0, 16'd0, 16'd0));
        send_sample(pack6(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_sample(pack6(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_sample(pack6(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        send_sample(pack6(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        send_sample(pack6(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        // roll and pitch angles in several quadrants, including x<0 pre-rotation
        send_sample(pack6(16'd0, 16'd0, 16'(-4096), 16'd0, 16'd0, 16'd0));
        send_sample(pack6(16'd0, 16'd0, 16'd4096, 16'd0, 16'd0, 16'd0));
        send_sample(pack6(16'd4096, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_sample(pack6(16'(-4096), 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_sample(pack6(16'd0, 16'd4096, 16'd0, 16'd0, 16'd0, 16'd0));
        send_sample(pack6(16'd0, 16'(-4096), 16'd0, 16'd0, 16'd0, 16'd0));
        send_sample(pack6(16'(-287), 16'(-369), 16'(-4096), 16'd0, 16'd0, 16'd0));
        send_sample(pack6(16'd1000, 16'd2000, 16'd3000, 16'd320, 16'(-320), 16'd160));
        send_sample(pack6(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        send_sample(pack6(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));

        // heaviest gyro weight and period, gyros pushed toward saturation;
        // the receiver holds off for a long stretch meanwhile
        load_setting(-4096, -4096, -4096, -4096, -4096, 65535, 65535, 65535);
        push_gyro = 1'b1;
        long_hold_req = 1'b1;
        random_run(220);
        push_gyro = 1'b0;

        // pure accelerometer angles, yaw wiped each step, shortest nonzero period
        load_setting(4095, 4095, 4095, 4095, 4095, 0, 0, 1);
        random_run(190);

        // zero sample period: no gyro contribution at all
        load_setting($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                     $urandom_range(8191), $urandom_range(8191),
                     $urandom_range(65535), $urandom_range(65535), 0);
        random_run(190);

        load_setting($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                     $urandom_range(8191), $urandom_range(8191),
                     $urandom_range(65535), $urandom_range(65535),
                     $urandom_range(65535, 1));
        random_run(190);

        // back to defaults, full throughput on both sides
        load_setting(287, 369, 8192 - 737, 19, 8192 - 10, 52429, 64881, 1638);
        quiet = 1'b1;
        random_run(240);

        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (300) @(negedge i_clk);

        $display("Covered %0d IMU words across %0d register settings,", words_sent,
                 settings_run);
        $display("including offset, gain and period extremes and a long output stall.");
        if (fail_count == 0) begin
            $display("** imu_complementary_attitude_filter: PASSED **");
        end else begin
            $display("** imu_complementary_attitude_filter: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
src/acf_pkg.sv
src/acf_mac.sv
src/acf_angle.sv
src/imu_complementary_attitude_filter.sv
sim/acf_checker.sv
sim/testbench.sv
